>>> rtl/dcsd_pkg.sv
// Shared types, constants and the digit glyph table of the counter/display block.
package dcsd_pkg;

  // Register map (index = byte address / 4)
  localparam int unsigned CfgAddrW = 3;
  localparam logic [0:0] RegDebounce = 1'b0;
  localparam logic [0:0] RegBlink    = 1'b1;

  localparam logic [7:0]  DebounceReset = 8'd100;
  localparam logic [15:0] BlinkReset    = 16'd1000;
  localparam logic [13:0] CountLimit    = 14'd9999;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 32;

  typedef logic [3:0] bcd_t;

  // Decimal digits of the press count, thousands first
  typedef struct packed {
    bcd_t thou;
    bcd_t hund;
    bcd_t tens;
    bcd_t ones;
  } digits_t;

  // One result beat
  typedef struct packed {
    logic [13:0] count_value;
    logic        status_led;
    logic [3:0]  digit_enable_n;
    logic [6:0]  segments;
  } result_t;

  // Seven segment pattern for one decimal digit, bit0 = segment a
  function automatic logic [6:0] glyph(input bcd_t d);
    logic [6:0] g;
    unique case (d)
      4'd0:    g = 7'h3f;
      4'd1:    g = 7'h06;
      4'd2:    g = 7'h5b;
      4'd3:    g = 7'h4f;
      4'd4:    g = 7'h66;
      4'd5:    g = 7'h6d;
      4'd6:    g = 7'h7d;
      4'd7:    g = 7'h07;
      4'd8:    g = 7'h7f;
      4'd9:    g = 7'h6f;
      default: g = 7'h00;
    endcase
    return g;
  endfunction

endpackage

>>> rtl/dcsd_debounce.sv
// Button debouncer with a saturating press counter kept in binary and in BCD.
module dcsd_debounce (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              level_i,
  input  logic [7:0]        debounce_samples_i,
  output logic [13:0]       count_d_o,
  output dcsd_pkg::digits_t digits_o
);
  import dcsd_pkg::*;

  logic [13:0] count_q, count_d;
  digits_t     digits_q, digits_d;
  logic        await_low_q, await_low_d;
  logic [7:0]  run_left_q, run_left_d;
  logic        wanted;
  logic        bump;

  assign wanted = ~await_low_q;

  // Run tracking and press detection
  always_comb begin
    await_low_d = await_low_q;
    run_left_d  = run_left_q;
    bump        = 1'b0;
    if (level_i != wanted) begin
      run_left_d = debounce_samples_i;
    end else if (run_left_q <= 8'd1) begin
      bump        = await_low_q && (count_q != CountLimit);
      await_low_d = ~await_low_q;
      run_left_d  = debounce_samples_i;
    end else begin
      run_left_d = run_left_q - 8'd1;
    end
  end

  // Count increment, binary and decimal in step
  always_comb begin
    count_d  = count_q;
    digits_d = digits_q;
    if (bump) begin
      count_d = count_q + 14'd1;
      if (digits_q.ones != 4'd9) begin
        digits_d.ones = digits_q.ones + 4'd1;
      end else begin
        digits_d.ones = 4'd0;
        if (digits_q.tens != 4'd9) begin
          digits_d.tens = digits_q.tens + 4'd1;
        end else begin
          digits_d.tens = 4'd0;
          if (digits_q.hund != 4'd9) begin
            digits_d.hund = digits_q.hund + 4'd1;
          end else begin
            digits_d.hund = 4'd0;
            digits_d.thou = digits_q.thou + 4'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      digits_q    <= '0;
      await_low_q <= 1'b0;
      run_left_q  <= DebounceReset;
    end else if (step_i) begin
      count_q     <= count_d;
      digits_q    <= digits_d;
      await_low_q <= await_low_d;
      run_left_q  <= run_left_d;
    end
  end

  assign count_d_o = step_i ? count_d : count_q;
  assign digits_o  = digits_q;

endmodule

>>> rtl/dcsd_display.sv
// Digit scan with leading-zero blanking, segment/enable latches and status LED blinker.
module dcsd_display (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              tick_i,
  input  dcsd_pkg::digits_t digits_i,
  input  logic [15:0]       blink_reload_i,
  output logic [6:0]        segments_o,
  output logic [3:0]        digit_en_n_o,
  output logic              led_o
);
  import dcsd_pkg::*;

  logic [1:0]  pos_q;
  logic [15:0] blink_left_q, blink_left_d;
  logic        phase_q, phase_d;
  logic        led_q, led_d;
  logic [6:0]  seg_q, seg_d;
  logic [3:0]  dig_q, dig_d;
  logic        blank0, blank1, blank2;
  bcd_t        sel_digit;
  logic        sel_blank;
  logic        adv;

  assign adv = step_i & tick_i;

  // Leading-zero blanking
  assign blank0 = (digits_i.thou == 4'd0);
  assign blank1 = blank0 && (digits_i.hund == 4'd0);
  assign blank2 = blank1 && (digits_i.tens == 4'd0);

  always_comb begin
    unique case (pos_q)
      2'd0: begin sel_digit = digits_i.thou; sel_blank = blank0; end
      2'd1: begin sel_digit = digits_i.hund; sel_blank = blank1; end
      2'd2: begin sel_digit = digits_i.tens; sel_blank = blank2; end
      default: begin sel_digit = digits_i.ones; sel_blank = 1'b0; end
    endcase
  end

  // Next latch and blinker values on a tick
  always_comb begin
    blink_left_d = blink_left_q;
    phase_d      = phase_q;
    led_d        = led_q;
    seg_d        = seg_q;
    dig_d        = dig_q;
    if (adv) begin
      if (blink_left_q == 16'd0) begin
        blink_left_d = blink_reload_i - 16'd1;
        led_d        = phase_q;
        phase_d      = ~phase_q;
      end else begin
        blink_left_d = blink_left_q - 16'd1;
      end
      seg_d = sel_blank ? 7'h00 : glyph(sel_digit);
      dig_d = ~(4'b0001 << pos_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      blink_left_q <= BlinkReset;
      phase_q      <= 1'b0;
      led_q        <= 1'b0;
      seg_q        <= '0;
      dig_q        <= '0;
    end else if (adv) begin
      pos_q        <= pos_q + 2'd1;
      blink_left_q <= blink_left_d;
      phase_q      <= phase_d;
      led_q        <= led_d;
      seg_q        <= seg_d;
      dig_q        <= dig_d;
    end
  end

  assign segments_o   = seg_d;
  assign digit_en_n_o = dig_d;
  assign led_o        = led_d;

endmodule

>>> rtl/debounced_counter_seven_segment_display_unit.sv
// Top level: config registers, debouncer, display scan and two-entry result buffer.
// Each result beat is registered into the output or skid entry as its input beat is accepted.
// Throughput: one beat per cycle unless skid full; state update is a single registered pass.
// A two-entry result buffer keeps input accepted while one result waits downstream.
// Reset (rst_ni, async, low): count, scan and latches clear, registers take 100 and 1000.
// No clearing pass; the block accepts beats as soon as reset is released.
module debounced_counter_seven_segment_display_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // APB configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dcsd_pkg::CfgAddrW-1:0]      paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // Input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [0] button_level, [1] scan_tick, [7:2] zero
  input  logic [dcsd_pkg::InDataW-1:0]       s_axis_tdata,
  // Result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [6:0] segments, [10:7] digit_enable_n, [11] status_led, [25:12] count_value, [31:26] zero
  output logic [dcsd_pkg::OutDataW-1:0]      m_axis_tdata
);
  import dcsd_pkg::*;

  logic [7:0]  debounce_q;
  logic [15:0] blink_q;
  logic        cfg_wr;
  logic [0:0]  reg_idx;
  logic        push, pop;
  logic [13:0] count_d;
  digits_t     digits;
  result_t     res;
  result_t     out_q, skid_q;
  logic        out_vld_q, skid_vld_q;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[2:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceReset;
      blink_q    <= BlinkReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegDebounce: debounce_q <= pwdata[7:0];
        default:     blink_q    <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegDebounce: prdata = {24'd0, debounce_q};
      default:     prdata = {16'd0, blink_q};
    endcase
  end

  // Handshakes
  assign s_axis_tready = ~skid_vld_q;
  assign push          = s_axis_tvalid & s_axis_tready;
  assign pop           = m_axis_tvalid & m_axis_tready;

  dcsd_debounce u_debounce (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (push),
    .level_i            (s_axis_tdata[0]),
    .debounce_samples_i (debounce_q),
    .count_d_o          (count_d),
    .digits_o           (digits)
  );

  dcsd_display u_display (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (push),
    .tick_i         (s_axis_tdata[1]),
    .digits_i       (digits),
    .blink_reload_i (blink_q),
    .segments_o     (res.segments),
    .digit_en_n_o   (res.digit_enable_n),
    .led_o          (res.status_led)
  );

  assign res.count_value = count_d;

  // Result buffer: output register plus skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (pop) begin
        skid_vld_q <= 1'b0;
      end
    end else if (push) begin
      if (out_vld_q && !pop) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (pop) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_vld_q && !pop) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, out_q};

endmodule
